/* design/mpe_pkg.sv */
package mpe_pkg;

	// function codes of an input item
	localparam logic [1:0] FUNC_COEF  = 2'd0;
	localparam logic [1:0] FUNC_POWER = 2'd1;
	localparam logic [1:0] FUNC_RANGE = 2'd2;
	localparam logic [1:0] FUNC_X     = 2'd3;

	// configuration register indexes
	localparam int CFG_AW = 2;
	localparam logic [CFG_AW-1:0] REG_POLY_KIND   = 2'd0;
	localparam logic [CFG_AW-1:0] REG_NUM_VARS    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_NUM_TERMS   = 2'd2;
	localparam logic [CFG_AW-1:0] REG_MEAN_OFFSET = 2'd3;

	// recurrence kinds, anything else runs as monomial
	localparam logic [1:0] KIND_CHEB = 2'd1;
	localparam logic [1:0] KIND_LEG  = 2'd2;

	// table sizes, tied to the index widths of an input item
	localparam int MAX_VARS  = 8;
	localparam int MAX_TERMS = 64;

	localparam int PCW = 4;

	typedef struct packed {
		logic [1:0]         func;
		logic [5:0]         term_index;
		logic [2:0]         var_index;
		logic signed [31:0] value;
		logic signed [31:0] value_max;
		logic [PCW-1:0]     power_code;
		logic               last;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               saturated;
		logic               range_error;
	} out_item_t;

	// clip to 32 bits signed, msb of the return value flags a clip
	function automatic logic [32:0] sat32(input logic signed [63:0] x);
		logic [32:0] r;
		if (x > 64'sd2147483647) begin
			r = {1'b1, 32'h7fffffff};
		end else if (x < -64'sd2147483648) begin
			r = {1'b1, 32'h80000000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

endpackage

/* design/mpe_ram.sv */
module mpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* design/mpe_div.sv */
module mpe_div #(
	parameter int DW = 49,
	parameter int VW = 33
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quot
);
	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, num_q[DW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			num_q <= {num_q[DW-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;
endmodule

/* design/multivariate_polynomial_expansion_eval.sv */
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_data (func, indexes, values, code, last)
// out     | out | out_valid/out_ready | out_data (result, saturated, range_error)
// cfg     | in  | cfg_we              | cfg_addr, cfg_wdata
//
// a load or an x item without last is stored while the block stays idle
// an x item with last runs an evaluation: a mapping step per variable, then per
// term and variable the basis factor by recurrence (monomial, Chebyshev or
// Legendre); the mapping and the Legendre step share the bit-serial divider,
// which is DW = 33+FRAC_BITS bits wide
// reset clears control and the configuration registers (num_vars to 1), tables hold garbage until loaded
// the finished result waits in the output register while new items are taken
module multivariate_polynomial_expansion_eval #(
	parameter int MAX_POWER = 15,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  mpe_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output mpe_pkg::out_item_t        out_data,
	input  logic                      cfg_we,
	input  logic [mpe_pkg::CFG_AW-1:0] cfg_addr,
	input  logic [31:0]               cfg_wdata
);
	import mpe_pkg::*;

	localparam int AW_C  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int DEP_P = MAX_TERMS * MAX_VARS;
	localparam int AW_P  = (DEP_P > 1) ? $clog2(DEP_P) : 1;
	localparam int AW_V  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
	localparam int CW_T  = $clog2(MAX_TERMS + 1);
	localparam int CW_V  = $clog2(MAX_VARS + 1);
	localparam int DW    = 33 + FRAC_BITS;
	localparam int SUMW  = CW_T + 34;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] ONE32 = 32'(ONE);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_VSTART = 4'd1;
	localparam logic [3:0] S_VWAIT  = 4'd2;
	localparam logic [3:0] S_TSTART = 4'd3;
	localparam logic [3:0] S_TCOEF  = 4'd4;
	localparam logic [3:0] S_PREQ   = 4'd5;
	localparam logic [3:0] S_PDATA  = 4'd6;
	localparam logic [3:0] S_FAC    = 4'd7;
	localparam logic [3:0] S_MUL    = 4'd8;
	localparam logic [3:0] S_REC    = 4'd9;
	localparam logic [3:0] S_LA     = 4'd10;
	localparam logic [3:0] S_LB     = 4'd11;
	localparam logic [3:0] S_LDIV   = 4'd12;
	localparam logic [3:0] S_TMUL   = 4'd13;
	localparam logic [3:0] S_DONE   = 4'd14;

	// configuration
	logic [1:0]         poly_kind_q;
	logic [3:0]         num_vars_q;
	logic [6:0]         num_terms_q;
	logic signed [31:0] mean_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_kind_q   <= '0;
			num_vars_q    <= 4'd1;
			num_terms_q   <= '0;
			mean_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_POLY_KIND:   poly_kind_q   <= cfg_wdata[1:0];
				REG_NUM_VARS:    num_vars_q    <= cfg_wdata[3:0];
				REG_NUM_TERMS:   num_terms_q   <= cfg_wdata[6:0];
				REG_MEAN_OFFSET: mean_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [CW_V-1:0] nv;
	logic [CW_T-1:0] nt;
	assign nv = (32'(num_vars_q) > MAX_VARS) ? CW_V'(MAX_VARS) : CW_V'(num_vars_q);
	assign nt = (32'(num_terms_q) > MAX_TERMS) ? CW_T'(MAX_TERMS) : CW_T'(num_terms_q);

	logic [3:0]         state_q;
	logic [CW_T-1:0]    i_q;
	logic [CW_V-1:0]    j_q;
	logic [4:0]         k_q;
	logic [4:0]         code_q;
	logic signed [31:0] term_q;
	logic signed [31:0] f_q;
	logic signed [31:0] p1_q;
	logic signed [31:0] p2_q;
	logic signed [31:0] pv_q;
	logic signed [38:0] la_q;
	logic               nsign_q;
	logic               sat_q;
	logic               rerr_q;
	logic signed [SUMW-1:0] sum_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic signed [31:0] x_q    [MAX_VARS];
	logic signed [31:0] rmin_q [MAX_VARS];
	logic signed [31:0] rmax_q [MAX_VARS];
	logic signed [31:0] v_q    [MAX_VARS];

	logic acc;
	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	logic ti_ok;
	logic vi_ok;
	assign ti_ok = 32'(in_data.term_index) < MAX_TERMS;
	assign vi_ok = 32'(in_data.var_index) < MAX_VARS;

	// table memories
	logic [31:0]    coef_rdata;
	logic [PCW-1:0] pow_rdata;
	logic           coef_we;
	logic           pow_we;
	assign coef_we = acc && in_data.func == FUNC_COEF && ti_ok;
	assign pow_we  = acc && in_data.func == FUNC_POWER && ti_ok && vi_ok;

	mpe_ram #(.WIDTH(32), .DEPTH(MAX_TERMS)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (AW_C'(32'(in_data.term_index))),
		.wdata (in_data.value),
		.raddr (i_q[AW_C-1:0]),
		.rdata (coef_rdata)
	);

	mpe_ram #(.WIDTH(PCW), .DEPTH(DEP_P)) u_pow (
		.clk   (clk),
		.we    (pow_we),
		.waddr (AW_P'(32'(in_data.term_index) * MAX_VARS + 32'(in_data.var_index))),
		.wdata (in_data.power_code),
		.raddr (AW_P'(32'(i_q) * MAX_VARS + 32'(j_q))),
		.rdata (pow_rdata)
	);

	// per-variable stores, written by load and x items
	always_ff @(posedge clk) begin
		if (acc && vi_ok && in_data.func == FUNC_RANGE) begin
			rmin_q[AW_V'(32'(in_data.var_index))] <= in_data.value;
			rmax_q[AW_V'(32'(in_data.var_index))] <= in_data.value_max;
		end
		if (acc && vi_ok && in_data.func == FUNC_X) begin
			x_q[AW_V'(32'(in_data.var_index))] <= in_data.value;
		end
	end

	logic [AW_V-1:0]    jv;
	logic signed [31:0] cur_v;
	assign jv    = j_q[AW_V-1:0];
	assign cur_v = v_q[jv];

	// shared q-format multiplier
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod;
	logic [32:0]        mul_sat;
	assign mul_a   = (state_q == S_TMUL) ? term_q : p2_q;
	assign mul_b   = (state_q == S_TMUL) ? f_q : cur_v;
	assign prod    = mul_a * mul_b;
	assign mul_sat = sat32(prod >>> FRAC_BITS);

	// mapping numerator and range
	logic signed [32:0] rng;
	logic signed [32:0] xd;
	logic [32:0]        rng_mag;
	logic [DW-1:0]      xd_mag;
	assign rng     = 33'(rmax_q[jv]) - 33'(rmin_q[jv]);
	assign xd      = 33'(x_q[jv]) - 33'(rmax_q[jv]);
	assign rng_mag = rng[32] ? 33'(-rng) : 33'(rng);
	assign xd_mag  = DW'(xd[32] ? 33'(-xd) : 33'(xd)) << (FRAC_BITS + 1);

	// legendre step terms
	logic signed [6:0]  c_a;
	logic signed [5:0]  c_b;
	logic signed [38:0] la_prod;
	logic signed [37:0] lb_prod;
	logic signed [39:0] lnum;
	logic [39:0]        lnum_mag;
	assign c_a      = signed'({1'b0, 6'({k_q, 1'b0} - 6'd3)});
	assign c_b      = signed'({1'b0, 5'(k_q - 5'd2)});
	assign la_prod  = pv_q * c_a;
	assign lb_prod  = p1_q * c_b;
	assign lnum     = 40'(la_q) - 40'(lb_prod);
	assign lnum_mag = lnum[39] ? 40'(-lnum) : 40'(lnum);

	// divider
	logic          div_start;
	logic          div_busy;
	logic          div_done;
	logic [DW-1:0] div_num;
	logic [32:0]   div_den;
	logic [DW-1:0] div_quot;
	logic signed [63:0] quot_s;
	logic signed [63:0] quot_signed;

	assign div_start = (state_q == S_VSTART && rng != 0) || state_q == S_LB;
	assign div_num   = (state_q == S_LB) ? DW'(lnum_mag) : xd_mag;
	assign div_den   = (state_q == S_LB) ? 33'(5'(k_q - 5'd1)) : rng_mag;

	mpe_div #(.DW(DW), .VW(33)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign quot_s      = 64'(signed'({1'b0, div_quot}));
	assign quot_signed = nsign_q ? -quot_s : quot_s;

	logic [32:0] v_sat;
	assign v_sat = sat32(ONE + quot_signed);

	// next recurrence value
	logic [32:0] p3_sat;
	always_comb begin
		if (state_q == S_LDIV) begin
			p3_sat = sat32(quot_signed);
		end else if (poly_kind_q == KIND_CHEB) begin
			p3_sat = sat32((64'(pv_q) <<< 1) - 64'(p1_q));
		end else begin
			p3_sat = {1'b0, pv_q};
		end
	end

	logic [4:0] code_clamped;
	assign code_clamped = (5'(pow_rdata) > 5'(MAX_POWER)) ? 5'(MAX_POWER) : 5'(pow_rdata);

	logic last_var;
	logic last_term;
	assign last_var  = CW_V'(j_q + 1'b1) == nv;
	assign last_term = CW_T'(i_q + 1'b1) == nt;

	logic [32:0] sum_sat;
	assign sum_sat = sat32(64'(sum_q));

	// evaluation sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			sat_q       <= 1'b0;
			rerr_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc && in_data.func == FUNC_X && in_data.last) begin
						sat_q  <= 1'b0;
						rerr_q <= 1'b0;
						sum_q  <= SUMW'(mean_offset_q);
						i_q    <= '0;
						j_q    <= '0;
						if (nv != 0) begin
							state_q <= S_VSTART;
						end else if (nt == 0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_TSTART;
						end
					end
				end
				S_VSTART: begin
					nsign_q <= xd[32] ^ rng[32];
					if (rng == 0) begin
						rerr_q  <= 1'b1;
						v_q[jv] <= '0;
						if (last_var) begin
							j_q     <= '0;
							state_q <= (nt == 0) ? S_DONE : S_TSTART;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end else begin
						state_q <= S_VWAIT;
					end
				end
				S_VWAIT: begin
					if (div_done) begin
						v_q[jv] <= v_sat[31:0];
						sat_q   <= sat_q | v_sat[32];
						if (last_var) begin
							j_q     <= '0;
							state_q <= (nt == 0) ? S_DONE : S_TSTART;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_VSTART;
						end
					end
				end
				S_TSTART: begin
					state_q <= S_TCOEF;
				end
				S_TCOEF: begin
					term_q <= coef_rdata;
					code_q <= code_clamped;
					if (nv != 0) begin
						state_q <= S_FAC;
					end else begin
						sum_q <= sum_q + SUMW'(signed'(coef_rdata));
						i_q   <= i_q + 1'b1;
						state_q <= last_term ? S_DONE : S_TSTART;
					end
				end
				S_PREQ: begin
					state_q <= S_PDATA;
				end
				S_PDATA: begin
					code_q  <= code_clamped;
					state_q <= S_FAC;
				end
				S_FAC: begin
					p1_q <= ONE32;
					p2_q <= cur_v;
					k_q  <= 5'd3;
					case (code_q)
						5'd0: begin
							f_q     <= '0;
							state_q <= S_TMUL;
						end
						5'd1: begin
							f_q     <= ONE32;
							state_q <= S_TMUL;
						end
						5'd2: begin
							f_q     <= cur_v;
							state_q <= S_TMUL;
						end
						default: state_q <= S_MUL;
					endcase
				end
				S_MUL: begin
					pv_q    <= mul_sat[31:0];
					sat_q   <= sat_q | mul_sat[32];
					state_q <= (poly_kind_q == KIND_LEG) ? S_LA : S_REC;
				end
				S_LA: begin
					la_q    <= la_prod;
					state_q <= S_LB;
				end
				S_LB: begin
					nsign_q <= lnum[39];
					state_q <= S_LDIV;
				end
				S_REC, S_LDIV: begin
					if (state_q == S_REC || div_done) begin
						sat_q <= sat_q | p3_sat[32];
						p1_q  <= p2_q;
						p2_q  <= p3_sat[31:0];
						if (k_q == code_q) begin
							f_q     <= p3_sat[31:0];
							state_q <= S_TMUL;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_TMUL: begin
					term_q <= mul_sat[31:0];
					sat_q  <= sat_q | mul_sat[32];
					if (last_var) begin
						sum_q   <= sum_q + SUMW'(signed'(mul_sat[31:0]));
						i_q     <= i_q + 1'b1;
						j_q     <= '0;
						state_q <= last_term ? S_DONE : S_TSTART;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_PREQ;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_q.result      <= sum_sat[31:0];
			out_q.saturated   <= sat_q | sum_sat[32];
			out_q.range_error <= rerr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// divider is never restarted while running
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// a finished evaluation lands in a free output register
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid_q) |=> out_valid_q)
		else $error("result not loaded");

	// a last x item starts an evaluation
	a_eval_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.func == FUNC_X && in_data.last) |=> state_q != S_IDLE)
		else $error("evaluation not started");

endmodule

/* verif/tb_multivariate_polynomial_expansion_eval.sv */
module tb_multivariate_polynomial_expansion_eval;
	timeunit 1ns;
	timeprecision 1ps;
	import mpe_pkg::*;

	localparam int NVAR = 8;
	localparam int NTERM = 64;
	localparam int NPOW = 15;
	localparam int STALL_LIMIT = 600000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [31:0] cfg_wdata;

	multivariate_polynomial_expansion_eval u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the block's registers and tables
	logic [1:0] kind_sh;
	logic [3:0] nvars_sh;
	logic [6:0] nterms_sh;
	longint mean_sh;
	longint coef_sh [NTERM];
	logic [3:0] pow_sh [NTERM*NVAR];
	longint rmin_sh [NVAR];
	longint rmax_sh [NVAR];
	longint x_sh [NVAR];
	bit coef_ok [NTERM];
	bit pow_ok [NTERM*NVAR];
	bit rng_ok [NVAR];
	bit x_ok [NVAR];

	out_item_t pending_evals [$];
	int mismatches = 0;
	int idle_in = 0;
	int idle_out = 0;
	int items_sent = 0;
	int stall_cnt = 0;

	typedef struct {
		bit do_cfg;
		logic [1:0] kind;
		logic [3:0] nv;
		logic [6:0] nt;
		logic [31:0] mean;
		in_item_t item;
		bit typed;
		out_item_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint clip32(longint x, inout bit clip);
		if (x > 64'sd2147483647) begin
			clip = 1;
			return 64'sd2147483647;
		end
		if (x < -64'sd2147483648) begin
			clip = 1;
			return -64'sd2147483648;
		end
		return x;
	endfunction

	// q16 product, floored
	function automatic longint qmul(longint a, longint b, inout bit clip);
		longint p;
		p = a * b;
		return clip32(p >>> 16, clip);
	endfunction

	function automatic longint basis_factor(int code, longint v, logic [1:0] kind,
			inout bit clip);
		longint p1, p2, p3, pv, num;
		p1 = 64'sd65536;
		p2 = v;
		p3 = 0;
		if (code == 0) return 0;
		if (code == 1) return 64'sd65536;
		if (code == 2) return v;
		for (int k = 3; k <= code; k++) begin
			pv = qmul(p2, v, clip);
			if (kind == KIND_CHEB) begin
				p3 = clip32(2 * pv - p1, clip);
			end else if (kind == KIND_LEG) begin
				num = longint'(2 * k - 3) * pv - longint'(k - 2) * p1;
				p3 = clip32(num / longint'(k - 1), clip);
			end else begin
				p3 = pv;
			end
			p1 = p2;
			p2 = p3;
		end
		return p3;
	endfunction

	// evaluate the expansion over the shadow tables
	function automatic out_item_t expand_eval();
		out_item_t r;
		bit clip, rerr;
		int nv, nt, code;
		longint vv [NVAR];
		longint sum, rng, num, term;
		clip = 0;
		rerr = 0;
		nv = (nvars_sh > NVAR) ? NVAR : nvars_sh;
		nt = (nterms_sh > NTERM) ? NTERM : nterms_sh;
		sum = mean_sh;
		for (int j = 0; j < nv; j++) begin
			rng = rmax_sh[j] - rmin_sh[j];
			if (rng == 0) begin
				rerr = 1;
				vv[j] = 0;
			end else begin
				num = (x_sh[j] - rmax_sh[j]) * 2 * 64'sd65536;
				vv[j] = clip32(64'sd65536 + num / rng, clip);
			end
		end
		for (int i = 0; i < nt; i++) begin
			term = coef_sh[i];
			for (int j = 0; j < nv; j++) begin
				code = pow_sh[i*NVAR + j];
				if (code > NPOW) code = NPOW;
				term = qmul(term, basis_factor(code, vv[j], kind_sh, clip), clip);
			end
			sum += term;
		end
		sum = clip32(sum, clip);
		r.result = sum[31:0];
		r.saturated = clip;
		r.range_error = rerr;
		return r;
	endfunction

	// update the shadow state for one accepted item, queue a result if any
	function automatic void absorb_item(in_item_t it, bit typed, out_item_t want);
		case (it.func)
			FUNC_COEF: begin
				coef_sh[it.term_index] = longint'(it.value);
				coef_ok[it.term_index] = 1;
			end
			FUNC_POWER: begin
				pow_sh[it.term_index*NVAR + it.var_index] = it.power_code;
				pow_ok[it.term_index*NVAR + it.var_index] = 1;
			end
			FUNC_RANGE: begin
				rmin_sh[it.var_index] = longint'(it.value);
				rmax_sh[it.var_index] = longint'(it.value_max);
				rng_ok[it.var_index] = 1;
			end
			default: begin
				x_sh[it.var_index] = longint'(it.value);
				x_ok[it.var_index] = 1;
				if (it.last) pending_evals.push_back(typed ? want : expand_eval());
			end
		endcase
	endfunction

	task automatic send_item(in_item_t it, bit typed = 0, out_item_t want = '0);
		@(negedge clk);
		while ($urandom_range(99) < idle_in) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		absorb_item(it, typed, want);
		items_sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 0;
		while (pending_evals.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(logic [1:0] kind, logic [3:0] nv, logic [6:0] nt,
			logic [31:0] mean);
		logic [31:0] vals [4];
		vals = '{32'(kind), 32'(nv), 32'(nt), mean};
		for (int a = 0; a < 4; a++) begin
			@(negedge clk);
			cfg_we <= 1;
			cfg_addr <= CFG_AW'(a);
			cfg_wdata <= vals[a];
		end
		@(negedge clk);
		cfg_we <= 0;
		kind_sh = kind;
		nvars_sh = nv;
		nterms_sh = nt;
		mean_sh = longint'(signed'(mean));
	endtask

	function automatic logic [31:0] rnd_q();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] rnd_code();
		if ($urandom_range(0, 19) == 0) return 4'd15;
		return (kind_sh == KIND_LEG) ? 4'($urandom_range(0, 6)) : 4'($urandom_range(0, 15));
	endfunction

	function automatic in_item_t mk_item(logic [1:0] func, int ti, int vi);
		in_item_t it;
		it.func = func;
		it.term_index = 6'(ti);
		it.var_index = 3'(vi);
		it.value = rnd_q();
		it.value_max = $urandom;
		it.power_code = rnd_code();
		it.last = $urandom_range(0, 1);
		if (func == FUNC_RANGE) begin
			case ($urandom_range(0, 7))
				0: it.value_max = it.value;
				1: begin
					it.value = 32'h80000000;
					it.value_max = 32'h7fffffff;
				end
				2, 3: it.value_max = $urandom;
				default: it.value_max = it.value + $urandom_range(1, 32'h3ffff) - 32'h1ffff;
			endcase
		end
		if (func == FUNC_X) it.last = 0;
		return it;
	endfunction

	// load every entry the next evaluation reads that was never written
	task automatic fill_unwritten();
		int nv, nt;
		nv = (nvars_sh > NVAR) ? NVAR : nvars_sh;
		nt = (nterms_sh > NTERM) ? NTERM : nterms_sh;
		for (int j = 0; j < nv; j++) begin
			if (!rng_ok[j]) send_item(mk_item(FUNC_RANGE, $urandom_range(0, 63), j));
			if (!x_ok[j]) send_item(mk_item(FUNC_X, $urandom_range(0, 63), j));
		end
		for (int i = 0; i < nt; i++) begin
			if (!coef_ok[i]) send_item(mk_item(FUNC_COEF, i, $urandom_range(0, 7)));
			for (int j = 0; j < nv; j++)
				if (!pow_ok[i*NVAR + j]) send_item(mk_item(FUNC_POWER, i, j));
		end
	endtask

	// a few random loads, fills for unwritten entries, then x items ending with the evaluating one
	task automatic run_sequence();
		int nv, nt, nloads, ti, vi;
		in_item_t it;
		nv = (nvars_sh > NVAR) ? NVAR : nvars_sh;
		nt = (nterms_sh > NTERM) ? NTERM : nterms_sh;
		nloads = $urandom_range(0, 5);
		repeat (nloads) begin
			if ($urandom_range(0, 4) == 0) begin
				ti = $urandom_range(0, 63);
				vi = $urandom_range(0, 7);
			end else begin
				ti = (nt > 0) ? $urandom_range(0, nt - 1) : $urandom_range(0, 63);
				vi = $urandom_range(0, nv - 1);
			end
			send_item(mk_item(2'($urandom_range(0, 2)), ti, vi));
		end
		if ($urandom_range(0, 9) == 0)
			send_item(mk_item(FUNC_X, $urandom_range(0, 63), $urandom_range(0, 7)));
		fill_unwritten();
		for (int j = 0; j < nv; j++) begin
			it = mk_item(FUNC_X, $urandom_range(0, 63), j);
			if (j == nv - 1) it.last = 1;
			send_item(it);
		end
	endtask

	function automatic dir_row_t drow(bit c, logic [1:0] k, logic [3:0] nv, logic [6:0] nt,
			logic [31:0] m, logic [1:0] f, int ti, int vi, logic [31:0] v,
			logic [31:0] vm, logic [3:0] pc, bit l, bit typed, out_item_t w);
		dir_row_t r;
		r.do_cfg = c;
		r.kind = k;
		r.nv = nv;
		r.nt = nt;
		r.mean = m;
		r.item = '{f, 6'(ti), 3'(vi), v, vm, pc, l};
		r.typed = typed;
		r.want = w;
		return r;
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_evals.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_data);
			end else begin
				e = pending_evals.pop_front();
				if (e.result !== out_data.result || e.saturated !== out_data.saturated ||
						e.range_error !== out_data.range_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result exp %h/%b/%b got %h/%b/%b", e.result, e.saturated,
							e.range_error, out_data.result, out_data.saturated,
							out_data.range_error);
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
		if (stall_cnt >= STALL_LIMIT) begin
			$display("multivariate_polynomial_expansion_eval: mismatch");
			$finish;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_out);
	end

	initial begin
		logic [1:0] k;
		logic [3:0] nv;
		logic [6:0] nt;
		int nsets;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_addr = '0;
		cfg_wdata = '0;
		kind_sh = 0;
		nvars_sh = 1;
		nterms_sh = 0;
		mean_sh = 0;
		for (int i = 0; i < NTERM*NVAR; i++) begin
			pow_sh[i] = 0;
			pow_ok[i] = 0;
		end
		for (int i = 0; i < NTERM; i++) begin
			coef_sh[i] = 0;
			coef_ok[i] = 0;
		end
		for (int i = 0; i < NVAR; i++) begin
			rmin_sh[i] = 0;
			rmax_sh[i] = 0;
			x_sh[i] = 0;
			rng_ok[i] = 0;
			x_ok[i] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: reset state, register extremes, clipping, each kind and codes 0, 1, 2 and 15
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_RANGE, 0, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 5, 0, 0, 1, 1,
			'{32'h0, 1'b0, 1'b1}));
		dir_rows.push_back(drow(1, 0, 1, 0, 32'h7fffffff, FUNC_X, 0, 0, 0, 0, 0, 1, 1,
			'{32'h7fffffff, 1'b0, 1'b1}));
		dir_rows.push_back(drow(1, 0, 1, 0, 32'h80000000, FUNC_X, 0, 0, 0, 0, 0, 1, 1,
			'{32'h80000000, 1'b0, 1'b1}));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_RANGE, 0, 0, 32'h80000000,
			32'h7fffffff, 0, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_COEF, 0, 0, 32'h7fffffff, 0, 0, 0, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_POWER, 0, 0, 0, 0, 1, 0, 0, '0));
		dir_rows.push_back(drow(1, 0, 1, 1, 32'h7fffffff, FUNC_X, 0, 0, 0, 0, 0, 1, 1,
			'{32'h7fffffff, 1'b1, 1'b0}));
		dir_rows.push_back(drow(1, 0, 1, 1, 0, FUNC_POWER, 0, 0, 0, 0, 15, 0, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 32'h7fffffff, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 32'h80000000, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(1, KIND_CHEB, 1, 1, 0, FUNC_X, 0, 0, 0, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 32'h8000, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(1, KIND_LEG, 1, 1, 0, FUNC_X, 0, 0, 32'h12345678, 0, 0, 1, 0,
			'0));
		dir_rows.push_back(drow(1, 2'd3, 1, 1, 0, FUNC_X, 0, 0, 32'hc0000000, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_POWER, 63, 7, 0, 0, 2, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_POWER, 0, 0, 0, 0, 0, 0, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 0, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_POWER, 0, 0, 0, 0, 2, 0, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 32'h40000000, 0, 0, 1, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_COEF, 0, 0, 32'h80000000, 0, 0, 0, 0, '0));
		dir_rows.push_back(drow(0, 0, 0, 0, 0, FUNC_X, 0, 0, 32'h80000000, 0, 0, 1, 0, '0));
		foreach (dir_rows[r]) begin
			if (dir_rows[r].do_cfg) begin
				wait_idle();
				write_regs(dir_rows[r].kind, dir_rows[r].nv, dir_rows[r].nt, dir_rows[r].mean);
			end
			send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);
		end

		// random phases, each with its own register setting
		for (int p = 0; p < 12; p++) begin
			k = 2'(p % 4);
			nv = 4'($urandom_range(1, 3));
			nt = 7'($urandom_range(0, (k == KIND_LEG) ? 4 : 8));
			nsets = 0;
			if (p == 5) begin
				k = 2'd3;
				nv = 4'd15;
				nt = 7'd127;
			end else if (p == 9) begin
				k = KIND_CHEB;
				nv = 4'd8;
				nt = 7'd64;
			end else if (p == 2) begin
				nv = 4'd1;
				nt = 7'd0;
			end
			wait_idle();
			write_regs(k, nv, nt, rnd_q());
			if (p < 4) begin
				idle_in = 9;
				idle_out = 69;
			end else if (p < 8) begin
				idle_in = 69;
				idle_out = 9;
			end else begin
				idle_in = 0;
				idle_out = 0;
			end
			items_sent = 0;
			while ((p == 5 || p == 9) ? nsets < 3 : items_sent < 40) begin
				run_sequence();
				nsets++;
			end
		end

		@(negedge clk);
		in_valid <= 0;
		while (pending_evals.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("multivariate_polynomial_expansion_eval: match");
		end else begin
			$display("multivariate_polynomial_expansion_eval: mismatch");
		end
		$finish;
	end

endmodule
